// ----- hw/rtl/cmt_pkg.sv -----
package cmt_pkg;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_MERGE  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_INIT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [0:0] REG_VERTEX_COUNT  = 1'd0;
    localparam logic [0:0] REG_CLUSTER_COUNT = 1'd1;

    localparam logic [10:0] VERTEX_COUNT_RESET  = 11'd1024;
    localparam logic [8:0]  CLUSTER_COUNT_RESET = 9'd256;

    typedef enum logic [4:0] {
        C_NOP,
        C_ACCEPT,
        C_CLEAR,
        C_FILL,
        C_MV_RD_TAG,
        C_MV_RD_LINKS,
        C_MV_UNLINK,
        C_MV_APPEND,
        C_MG_RD_HI,
        C_MG_RD_LO,
        C_MG_LATCH_LO,
        C_WK_RD,
        C_WK_NEXT,
        C_MG_SPLICE,
        C_MG_COUNT,
        C_RPT_RD,
        C_RPT_OUT,
        C_ERR_OUT
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_FILL,
        S_MV_TAG,
        S_MV_LINKS,
        S_MV_UNLINK,
        S_MV_APPEND,
        S_MG_HI,
        S_MG_LO,
        S_MG_LATCH,
        S_WK_RD,
        S_WK_NEXT,
        S_MG_SPLICE,
        S_MG_COUNT,
        S_RPT_RD,
        S_RPT_OUT,
        S_ERR
    } t_state;

    typedef struct packed {
        t_op  op;
        logic initd;
        logic range_err;
        logic mv_same;
        logic lo_eq_hi;
        logic hi_empty;
        logic clear_last;
        logic fill_last;
        logic walk_done;
    } t_dp_status;

endpackage

// ----- hw/rtl/cmt_ram.sv -----
module cmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cmt_ctrl.sv -----
module cmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  cmt_pkg::t_dp_status i_status,
    output cmt_pkg::t_cmd       o_cmd
);
    import cmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = C_ACCEPT;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_status.op == OP_INIT) begin
                    n_state = S_CLEAR;
                end else if (!i_status.initd || i_status.range_err) begin
                    n_state = S_ERR;
                end else if (i_status.op == OP_MOVE) begin
                    n_state = S_MV_TAG;
                end else if (i_status.op == OP_MERGE && !i_status.lo_eq_hi) begin
                    n_state = S_MG_HI;
                end else begin
                    n_state = S_RPT_RD;
                end
            end
            S_CLEAR: begin
                o_cmd = C_CLEAR;
                if (i_status.clear_last) n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd = C_FILL;
                if (i_status.fill_last) n_state = S_RPT_RD;
            end
            S_MV_TAG: begin
                o_cmd   = C_MV_RD_TAG;
                n_state = S_MV_LINKS;
            end
            S_MV_LINKS: begin
                o_cmd   = C_MV_RD_LINKS;
                n_state = i_status.mv_same ? S_RPT_RD : S_MV_UNLINK;
            end
            S_MV_UNLINK: begin
                o_cmd   = C_MV_UNLINK;
                n_state = S_MV_APPEND;
            end
            S_MV_APPEND: begin
                o_cmd   = C_MV_APPEND;
                n_state = S_RPT_RD;
            end
            S_MG_HI: begin
                o_cmd   = C_MG_RD_HI;
                n_state = S_MG_LO;
            end
            S_MG_LO: begin
                o_cmd   = C_MG_RD_LO;
                n_state = i_status.hi_empty ? S_RPT_RD : S_MG_LATCH;
            end
            S_MG_LATCH: begin
                o_cmd   = C_MG_LATCH_LO;
                n_state = S_WK_RD;
            end
            S_WK_RD: begin
                o_cmd   = C_WK_RD;
                n_state = S_WK_NEXT;
            end
            S_WK_NEXT: begin
                o_cmd   = C_WK_NEXT;
                n_state = i_status.walk_done ? S_MG_SPLICE : S_WK_RD;
            end
            S_MG_SPLICE: begin
                o_cmd   = C_MG_SPLICE;
                n_state = S_MG_COUNT;
            end
            S_MG_COUNT: begin
                o_cmd   = C_MG_COUNT;
                n_state = S_RPT_RD;
            end
            S_RPT_RD: begin
                o_cmd   = C_RPT_RD;
                n_state = S_RPT_OUT;
            end
            S_RPT_OUT: begin
                o_cmd   = C_RPT_OUT;
                n_state = S_IDLE;
            end
            S_ERR: begin
                o_cmd   = C_ERR_OUT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/cmt_datapath.sv -----
module cmt_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_CLUSTERS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cmt_pkg::t_cmd       i_cmd,
    output cmt_pkg::t_dp_status o_dp_status,
    input  logic [1:0]          i_operation,
    input  logic [9:0]          i_vertex,
    input  logic [7:0]          i_cluster_a,
    input  logic [7:0]          i_cluster_b,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data,
    output logic                o_done,
    output logic [7:0]          o_vertex_cluster,
    output logic [10:0]         o_cluster_size,
    output logic                o_cluster_empty,
    output logic [1:0]          o_status
);
    import cmt_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int NW = VW + 1;

    logic [10:0]   r_cfg_v;
    logic [8:0]    r_cfg_c;
    logic          r_init;
    logic [NW-1:0] r_used_v;
    logic [CW:0]   r_used_c;

    t_op           r_op;
    logic [9:0]    r_v_in;
    logic [7:0]    r_a_in;
    logic [7:0]    r_b_in;

    logic [CW-1:0] r_sweep;
    logic [VW-1:0] r_fv;
    logic [CW-1:0] r_fc;
    logic [NW-1:0] r_rnd;

    logic [CW-1:0] r_old;
    logic [NW-1:0] r_cnt;
    logic [VW-1:0] r_hh;
    logic [VW-1:0] r_ht;
    logic [NW-1:0] r_clo;
    logic [VW-1:0] r_tlo;
    logic [NW-1:0] r_rem;
    logic [VW-1:0] r_wv;

    logic          r_done;
    logic [7:0]    r_vc;
    logic [10:0]   r_size;
    logic          r_empty;
    logic [1:0]    r_stat;

    logic          v_ok, a_ok, b_ok;
    logic [VW-1:0] va;
    logic [CW-1:0] aa, bb, lo, hi;
    logic [VW-1:0] fv_back;
    logic [NW-1:0] cnt_new;
    logic          is_head, is_tail;

    logic          cov_we, nxt_we, prv_we, hd_we, tl_we, cnt_we;
    logic [VW-1:0] cov_wa, nxt_wa, prv_wa, cov_ra, nxt_ra, prv_ra;
    logic [CW-1:0] hd_wa, tl_wa, cnt_wa, hd_ra, tl_ra, cnt_ra;
    logic [CW-1:0] cov_wd, cov_rd;
    logic [VW-1:0] nxt_wd, prv_wd, hd_wd, tl_wd;
    logic [VW-1:0] nxt_rd, prv_rd, hd_rd, tl_rd;
    logic [NW-1:0] cnt_wd, cnt_rd;

    assign v_ok    = 32'(r_v_in) < 32'(r_used_v);
    assign a_ok    = 32'(r_a_in) < 32'(r_used_c);
    assign b_ok    = 32'(r_b_in) < 32'(r_used_c);
    assign va      = VW'(r_v_in);
    assign aa      = CW'(r_a_in);
    assign bb      = CW'(r_b_in);
    assign lo      = (aa < bb) ? aa : bb;
    assign hi      = (aa < bb) ? bb : aa;
    assign fv_back = VW'(32'(r_fv) - 32'(r_used_c));
    assign cnt_new = (cnt_rd == '0) ? '0 : cnt_rd - NW'(1);
    assign is_head = (hd_rd == va);
    assign is_tail = (tl_rd == va);

    always_comb begin
        o_dp_status.op         = r_op;
        o_dp_status.initd      = r_init;
        o_dp_status.range_err  = ((r_op == OP_MOVE || r_op == OP_LOOKUP) && !(v_ok && a_ok))
                                 || (r_op == OP_MERGE && !(a_ok && b_ok));
        o_dp_status.mv_same    = (cov_rd == aa);
        o_dp_status.lo_eq_hi   = (lo == hi);
        o_dp_status.hi_empty   = (cnt_rd == '0);
        o_dp_status.clear_last = (r_sweep == CW'(MAX_CLUSTERS - 1));
        o_dp_status.fill_last  = (32'(r_fv) == 32'(r_used_v) - 32'd1);
        o_dp_status.walk_done  = (r_rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_v  <= VERTEX_COUNT_RESET;
            r_cfg_c  <= CLUSTER_COUNT_RESET;
            r_init   <= 1'b0;
            r_used_v <= '0;
            r_used_c <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= (i_cmd == C_RPT_OUT || i_cmd == C_ERR_OUT);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_VERTEX_COUNT:  r_cfg_v <= i_cfg_data;
                    REG_CLUSTER_COUNT: r_cfg_c <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_cmd == C_ACCEPT && t_op'(i_operation) == OP_INIT) begin
                r_init   <= 1'b1;
                r_used_v <= (r_cfg_v == '0) ? NW'(1) :
                            (32'(r_cfg_v) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_cfg_v);
                r_used_c <= (r_cfg_c == '0) ? (CW+1)'(1) :
                            (32'(r_cfg_c) > MAX_CLUSTERS) ? (CW+1)'(MAX_CLUSTERS)
                                                          : (CW+1)'(r_cfg_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_ACCEPT: begin
                r_op    <= t_op'(i_operation);
                r_v_in  <= i_vertex;
                r_a_in  <= i_cluster_a;
                r_b_in  <= i_cluster_b;
                r_sweep <= '0;
                r_fv    <= '0;
                r_fc    <= '0;
                r_rnd   <= '0;
            end
            C_CLEAR: r_sweep <= r_sweep + CW'(1);
            C_FILL: begin
                r_fv <= r_fv + VW'(1);
                if (r_fc == CW'(32'(r_used_c) - 32'd1)) begin
                    r_fc  <= '0;
                    r_rnd <= r_rnd + NW'(1);
                end else begin
                    r_fc <= r_fc + CW'(1);
                end
            end
            C_MV_RD_LINKS: r_old <= cov_rd;
            C_MG_RD_LO: begin
                r_cnt <= cnt_rd;
                r_hh  <= hd_rd;
                r_ht  <= tl_rd;
            end
            C_MG_LATCH_LO: begin
                r_clo <= cnt_rd;
                r_tlo <= tl_rd;
                r_wv  <= r_hh;
                r_rem <= r_cnt;
            end
            C_WK_RD:   r_rem <= r_rem - NW'(1);
            C_WK_NEXT: r_wv  <= nxt_rd;
            C_RPT_OUT: begin
                r_vc    <= v_ok ? 8'(cov_rd) : 8'd0;
                r_size  <= a_ok ? 11'(cnt_rd) : 11'd0;
                r_empty <= a_ok && (cnt_rd == '0);
                r_stat  <= ST_OK;
            end
            C_ERR_OUT: begin
                r_vc    <= 8'd0;
                r_size  <= 11'd0;
                r_empty <= 1'b0;
                r_stat  <= r_init ? ST_RANGE : ST_NO_INIT;
            end
            default: ;
        endcase
    end

    always_comb begin
        cov_we = 1'b0; cov_wa = va;     cov_wd = aa;  cov_ra = va;
        nxt_we = 1'b0; nxt_wa = fv_back; nxt_wd = r_fv; nxt_ra = va;
        prv_we = 1'b0; prv_wa = r_fv;   prv_wd = fv_back; prv_ra = va;
        hd_we  = 1'b0; hd_wa  = r_fc;   hd_wd  = r_fv; hd_ra = hi;
        tl_we  = 1'b0; tl_wa  = r_fc;   tl_wd  = r_fv; tl_ra = hi;
        cnt_we = 1'b0; cnt_wa = r_fc;   cnt_wd = r_rnd + NW'(1); cnt_ra = aa;
        unique case (i_cmd)
            C_CLEAR: begin
                hd_we  = 1'b1; hd_wa  = r_sweep; hd_wd  = '0;
                tl_we  = 1'b1; tl_wa  = r_sweep; tl_wd  = '0;
                cnt_we = 1'b1; cnt_wa = r_sweep; cnt_wd = '0;
            end
            C_FILL: begin
                cov_we = 1'b1; cov_wa = r_fv; cov_wd = r_fc;
                nxt_we = (r_rnd != '0);
                prv_we = (r_rnd != '0);
                hd_we  = (r_rnd == '0);
                tl_we  = 1'b1;
                cnt_we = 1'b1;
            end
            C_MV_RD_LINKS: begin
                hd_ra  = cov_rd;
                tl_ra  = cov_rd;
                cnt_ra = cov_rd;
            end
            C_MV_UNLINK: begin
                cnt_we = 1'b1; cnt_wa = r_old; cnt_wd = cnt_new;
                hd_we  = (cnt_new != '0) && is_head;  hd_wa  = r_old;  hd_wd  = nxt_rd;
                nxt_we = (cnt_new != '0) && !is_head; nxt_wa = prv_rd; nxt_wd = nxt_rd;
                tl_we  = (cnt_new != '0) && is_tail;  tl_wa  = r_old;  tl_wd  = prv_rd;
                prv_we = (cnt_new != '0) && !is_tail; prv_wa = nxt_rd; prv_wd = prv_rd;
                cov_we = 1'b1;
                tl_ra  = aa;
                cnt_ra = aa;
            end
            C_MV_APPEND: begin
                hd_we  = (cnt_rd == '0); hd_wa  = aa;    hd_wd  = va;
                nxt_we = (cnt_rd != '0); nxt_wa = tl_rd; nxt_wd = va;
                prv_we = (cnt_rd != '0); prv_wa = va;    prv_wd = tl_rd;
                tl_we  = 1'b1;           tl_wa  = aa;    tl_wd  = va;
                cnt_we = 1'b1;           cnt_wa = aa;    cnt_wd = cnt_rd + NW'(1);
            end
            C_MG_RD_HI: begin
                hd_ra  = hi;
                tl_ra  = hi;
                cnt_ra = hi;
            end
            C_MG_RD_LO: begin
                tl_ra  = lo;
                cnt_ra = lo;
            end
            C_WK_RD: begin
                cov_we = 1'b1; cov_wa = r_wv; cov_wd = lo;
                nxt_ra = r_wv;
            end
            C_MG_SPLICE: begin
                hd_we  = (r_clo == '0); hd_wa  = lo;    hd_wd  = r_hh;
                nxt_we = (r_clo != '0); nxt_wa = r_tlo; nxt_wd = r_hh;
                prv_we = (r_clo != '0); prv_wa = r_hh;  prv_wd = r_tlo;
                tl_we  = 1'b1;          tl_wa  = lo;    tl_wd  = r_ht;
                cnt_we = 1'b1;          cnt_wa = hi;    cnt_wd = '0;
            end
            C_MG_COUNT: begin
                cnt_we = 1'b1; cnt_wa = lo; cnt_wd = r_clo + r_cnt;
            end
            C_RPT_RD: begin
                cov_ra = va;
                cnt_ra = aa;
            end
            default: ;
        endcase
    end

    cmt_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_cov (
        .i_clk(i_clk), .i_we(cov_we), .i_waddr(cov_wa), .i_wdata(cov_wd),
        .i_raddr(cov_ra), .o_rdata(cov_rd)
    );
    cmt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd)
    );
    cmt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_prev (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_rd)
    );
    cmt_ram #(.WIDTH(VW), .DEPTH(MAX_CLUSTERS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd)
    );
    cmt_ram #(.WIDTH(VW), .DEPTH(MAX_CLUSTERS)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_rd)
    );
    cmt_ram #(.WIDTH(NW), .DEPTH(MAX_CLUSTERS)) u_count (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd)
    );

    assign o_done           = r_done;
    assign o_vertex_cluster = r_vc;
    assign o_cluster_size   = r_size;
    assign o_cluster_empty  = r_empty;
    assign o_status         = r_stat;

endmodule

// ----- hw/rtl/cluster_membership_table.sv -----
// A move of a vertex already in the target cluster skips the unlink and append, a merge of
// equal clusters goes straight to the report, a merge whose higher cluster is empty skips
// the walk and splice; initialize clears all MAX_CLUSTERS slots, then fills the used vertices.
// One request at a time; busy drops in the o_done cycle, where the next request may start.
// Single read port RAMs with registered reads; the merge walk visits each member in S_WK_RD then S_WK_NEXT.
// Synchronous active-low reset clears the controller and the initialized flag.
module cluster_membership_table #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_CLUSTERS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [9:0]  i_vertex,
    input  logic [7:0]  i_cluster_a,
    input  logic [7:0]  i_cluster_b,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    output logic        o_done,
    output logic [7:0]  o_vertex_cluster,
    output logic [10:0] o_cluster_size,
    output logic        o_cluster_empty,
    output logic [1:0]  o_status
);
    import cmt_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    cmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    cmt_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_CLUSTERS(MAX_CLUSTERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_dp_status      (dp_status),
        .i_operation      (i_operation),
        .i_vertex         (i_vertex),
        .i_cluster_a      (i_cluster_a),
        .i_cluster_b      (i_cluster_b),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_vertex_cluster (o_vertex_cluster),
        .o_cluster_size   (o_cluster_size),
        .o_cluster_empty  (o_cluster_empty),
        .o_status         (o_status)
    );

endmodule
